### rtl/lacp_rx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lacp receive machine package
// shared types, codes and tuple widths for the lacp receive machine
// ----------------------------------------------------------------------------
package lacp_rx_pkg;

   localparam int SYS_W   = 64;
   localparam int PORT_W  = 56;
   localparam int TICK_W  = 8;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_ACTOR_SYS    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTOR_PORT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PARTNER_SYS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PARTNER_PORT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_TICKS  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_TICKS   = 3'd5;

   // state octet bit positions
   localparam int B_ACT = 0;
   localparam int B_TMT = 1;
   localparam int B_AGG = 2;
   localparam int B_SYN = 3;
   localparam int B_DFL = 6;
   localparam int B_EXP = 7;

   localparam logic [PORT_W-1:0] PORT_CMP_MASK = 56'hFF_FFFF_FFFF_FF04;

   typedef enum logic [2:0] {
      RX_BEGIN = 3'd0,
      RX_INIT  = 3'd1,
      RX_PDIS  = 3'd2,
      RX_EXP   = 3'd3,
      RX_CUR   = 3'd4,
      RX_LDIS  = 3'd5,
      RX_DEF   = 3'd6
   } rx_state_type;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_APPLY,
      CTL_WALK,
      CTL_DONE
   } ctl_state_type;

   // controller to datapath
   typedef struct packed {
      logic         apply;   // load item flags, tick or pdu
      logic         enter;   // enter the state in target
      rx_state_type target;
      logic         clear;   // clear per-item hit flags
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic         stable;
      rx_state_type nxt;
   } dp_sts_type;

endpackage : lacp_rx_pkg
`default_nettype wire

### rtl/lacp_rx_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lacp receive datapath
// partner records, actor octet, timer and transition decode
// ----------------------------------------------------------------------------
module lacp_rx_datapath import lacp_rx_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [SYS_W-1:0]  csr_data,
   input  wire logic              item_op,
   input  wire logic              item_begin,
   input  wire logic              item_up,
   input  wire logic              item_lacp,
   input  wire logic              item_moved,
   input  wire logic [SYS_W-1:0]  item_ma_sys,
   input  wire logic [PORT_W-1:0] item_ma_port,
   input  wire logic [SYS_W-1:0]  item_mp_sys,
   input  wire logic [PORT_W-1:0] item_mp_port,
   input  wire dp_cmd_type        cmd,
   output dp_sts_type             sts,
   output logic [2:0]             rx_state,
   output logic [7:0]             actor_oct,
   output logic [7:0]             partner_oct,
   output logic                   ntt,
   output logic                   unsel,
   output logic [TICK_W-1:0]      timer
);

   logic [SYS_W-1:0]  a_sys_adm_ff, p_sys_adm_ff, a_sys_op_ff, p_sys_rec_ff;
   logic [SYS_W-1:0]  ma_sys_ff, mp_sys_ff;
   logic [PORT_W-1:0] a_port_adm_ff, p_port_adm_ff, a_port_op_ff, p_port_rec_ff;
   logic [PORT_W-1:0] ma_port_ff, mp_port_ff;
   logic [TICK_W-1:0] short_ff, long_ff, cw_ff;
   logic [7:0]        act_ff;
   rx_state_type      st_ff;
   logic              pend_ff, moved_ff, up_ff, lacp_ff, ntt_ff, unsel_ff;

   logic [SYS_W-1:0]  p_sys_in;
   logic [PORT_W-1:0] p_port_in;
   logic [TICK_W-1:0] cw_in;
   logic [7:0]        act_in;
   rx_state_type      st_in;
   logic              pend_in, moved_in, ntt_in, unsel_in;
   logic [PORT_W-1:0] a_full;
   logic [7:0]        ma, mp;
   logic              same_rec, same_act, same_def, match;

   assign a_full = {a_port_op_ff[PORT_W-1:8], act_ff};
   assign ma = ma_port_ff[7:0];
   assign mp = mp_port_ff[7:0];
   assign same_rec = (ma_sys_ff == p_sys_rec_ff) &&
                     (((ma_port_ff ^ p_port_rec_ff) & PORT_CMP_MASK) == '0);
   assign same_act = (mp_sys_ff == a_sys_op_ff) &&
                     (((mp_port_ff ^ a_full) & PORT_CMP_MASK) == '0);
   assign same_def = (p_sys_adm_ff == p_sys_rec_ff) &&
                     (((p_port_adm_ff ^ p_port_rec_ff) & PORT_CMP_MASK) == '0);
   assign match = (same_act || !ma[B_AGG]) && (ma[B_ACT] || (act_ff[B_ACT] && mp[B_ACT]));

   // transition decode
   always_comb begin
      sts.stable = 1'b1;
      sts.nxt    = RX_BEGIN;
      if (!up_ff && !moved_ff && st_ff != RX_BEGIN) begin
         sts.stable = (st_ff == RX_PDIS);
         sts.nxt    = RX_PDIS;
      end else begin
         unique case (st_ff)
            RX_BEGIN: begin sts.stable = 1'b0; sts.nxt = RX_INIT; end
            RX_INIT:  begin sts.stable = 1'b0; sts.nxt = RX_PDIS; end
            RX_PDIS: begin
               if (moved_ff) begin sts.stable = 1'b0; sts.nxt = RX_INIT; end
               else if (up_ff && lacp_ff) begin sts.stable = 1'b0; sts.nxt = RX_EXP; end
               else if (up_ff) begin sts.stable = 1'b0; sts.nxt = RX_LDIS; end
            end
            RX_LDIS: if (up_ff && lacp_ff) begin sts.stable = 1'b0; sts.nxt = RX_EXP; end
            RX_EXP: begin
               if (cw_ff == '0) begin sts.stable = 1'b0; sts.nxt = RX_DEF; end
               else if (pend_ff) begin sts.stable = 1'b0; sts.nxt = RX_CUR; end
            end
            RX_CUR: begin
               if (cw_ff == '0 && !pend_ff) begin sts.stable = 1'b0; sts.nxt = RX_EXP; end
               else if (pend_ff) begin sts.stable = 1'b0; sts.nxt = RX_CUR; end
            end
            RX_DEF: if (pend_ff) begin sts.stable = 1'b0; sts.nxt = RX_CUR; end
            default: ;
         endcase
      end
   end

   // state entry actions
   always_comb begin
      p_sys_in = p_sys_rec_ff;
      p_port_in = p_port_rec_ff;
      cw_in = cw_ff;
      act_in = act_ff;
      st_in = st_ff;
      pend_in = pend_ff;
      moved_in = moved_ff;
      ntt_in = ntt_ff;
      unsel_in = unsel_ff;
      if (cmd.clear) begin
         ntt_in = 1'b0;
         unsel_in = 1'b0;
      end
      if (cmd.apply) begin
         // a begin request clears the moved flag that the same word sets
         if (item_moved && !item_begin) moved_in = 1'b1;
         if (!item_op) begin
            if (cw_ff != '0) cw_in = cw_ff - 1'b1;
         end else if (item_lacp) begin
            pend_in = 1'b1;
         end
      end
      if (cmd.enter) begin
         st_in = cmd.target;
         unique case (cmd.target)
            RX_BEGIN, RX_INIT: begin
               unsel_in = 1'b1;
               act_in = a_port_adm_ff[7:0];
               act_in[B_DFL] = 1'b1;
               act_in[B_EXP] = 1'b0;
               p_sys_in = p_sys_adm_ff;
               p_port_in = p_port_adm_ff;
               moved_in = 1'b0;
            end
            RX_PDIS: begin
               p_port_in[B_SYN] = 1'b0;
               pend_in = 1'b0;
               cw_in = '0;
               unsel_in = 1'b1;
            end
            RX_LDIS: begin
               unsel_in = 1'b1;
               p_sys_in = p_sys_adm_ff;
               p_port_in = p_port_adm_ff;
               p_port_in[B_AGG] = 1'b0;
               act_in[B_DFL] = 1'b1;
            end
            RX_EXP: begin
               p_port_in[B_SYN] = 1'b0;
               p_port_in[B_TMT] = 1'b1;
               cw_in = short_ff;
               act_in[B_EXP] = 1'b1;
            end
            RX_DEF: begin
               if (!same_def) begin
                  unsel_in = 1'b1;
                  act_in[B_SYN] = 1'b0;
               end
               p_sys_in = p_sys_adm_ff;
               p_port_in = p_port_adm_ff;
               act_in[B_DFL] = 1'b1;
               act_in[B_EXP] = 1'b0;
            end
            default: begin // current
               if (!same_rec) unsel_in = 1'b1;
               if (!same_act || ((mp ^ act_ff) & 8'h0F) != 8'h00 || !match) ntt_in = 1'b1;
               p_sys_in = ma_sys_ff;
               p_port_in = ma_port_ff;
               p_port_in[B_SYN] = match && ma[B_SYN];
               act_in[B_DFL] = 1'b0;
               act_in[B_EXP] = 1'b0;
               cw_in = act_ff[B_TMT] ? short_ff : long_ff;
               pend_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_sys_adm_ff <= '0; a_port_adm_ff <= '0;
         p_sys_adm_ff <= '0; p_port_adm_ff <= '0;
         short_ff <= 8'd3; long_ff <= 8'd90;
         st_ff <= RX_BEGIN; act_ff <= '0; cw_ff <= '0;
         p_sys_rec_ff <= '0; p_port_rec_ff <= '0;
         pend_ff <= 1'b0; moved_ff <= 1'b0;
         ma_sys_ff <= '0; ma_port_ff <= '0; mp_sys_ff <= '0; mp_port_ff <= '0;
         a_sys_op_ff <= '0; a_port_op_ff <= '0;
         up_ff <= 1'b0; lacp_ff <= 1'b0; ntt_ff <= 1'b0; unsel_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_ACTOR_SYS:    a_sys_adm_ff <= csr_data;
               CSR_ACTOR_PORT:   a_port_adm_ff <= csr_data[PORT_W-1:0];
               CSR_PARTNER_SYS:  p_sys_adm_ff <= csr_data;
               CSR_PARTNER_PORT: p_port_adm_ff <= csr_data[PORT_W-1:0];
               CSR_SHORT_TICKS:  short_ff <= csr_data[TICK_W-1:0];
               CSR_LONG_TICKS:   long_ff <= csr_data[TICK_W-1:0];
               default: ;
            endcase
         end
         if (cmd.apply) begin
            up_ff <= item_up;
            lacp_ff <= item_lacp;
            if (item_op && item_lacp) begin
               ma_sys_ff <= item_ma_sys; ma_port_ff <= item_ma_port;
               mp_sys_ff <= item_mp_sys; mp_port_ff <= item_mp_port;
            end
         end
         if (cmd.enter && (cmd.target == RX_BEGIN || cmd.target == RX_INIT)) begin
            a_sys_op_ff <= a_sys_adm_ff;
            a_port_op_ff <= a_port_adm_ff;
         end
         st_ff <= st_in; act_ff <= act_in; cw_ff <= cw_in;
         p_sys_rec_ff <= p_sys_in; p_port_rec_ff <= p_port_in;
         pend_ff <= pend_in; moved_ff <= moved_in;
         ntt_ff <= ntt_in; unsel_ff <= unsel_in;
      end
   end

   assign rx_state = st_ff;
   assign actor_oct = act_ff;
   assign partner_oct = p_port_rec_ff[7:0];
   assign ntt = ntt_ff;
   assign unsel = unsel_ff;
   assign timer = cw_ff;

endmodule : lacp_rx_datapath
`default_nettype wire

### rtl/lacp_rx_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lacp receive controller
// sequences item apply and the transition walk, one transition a cycle
// ----------------------------------------------------------------------------
module lacp_rx_ctrl import lacp_rx_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_valid,
   output logic       req_stall,
   input  wire logic  req_begin,
   output logic       rsp_valid,
   input  wire logic  rsp_stall,
   input  wire dp_sts_type sts,
   output dp_cmd_type cmd
);

   ctl_state_type st_ff, st_in;
   logic [4:0]    hops_ff, hops_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= CTL_IDLE;
         hops_ff <= '0;
      end else begin
         st_ff <= st_in;
         hops_ff <= hops_in;
      end
   end

   always_comb begin
      st_in = st_ff;
      hops_in = hops_ff;
      cmd = '{apply: 1'b0, enter: 1'b0, target: RX_BEGIN, clear: 1'b0};
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (st_ff)
         CTL_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               // begin entry happens before the tick or pdu is applied
               cmd.clear = 1'b1;
               cmd.enter = req_begin;
               st_in = CTL_APPLY;
            end
         end
         CTL_APPLY: begin
            cmd.apply = 1'b1;
            hops_in = '0;
            st_in = CTL_WALK;
         end
         CTL_WALK: begin
            if (sts.stable || hops_ff == 5'd16) begin
               st_in = CTL_DONE;
            end else begin
               cmd.enter = 1'b1;
               cmd.target = sts.nxt;
               hops_in = hops_ff + 5'd1;
            end
         end
         default: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) st_in = CTL_IDLE;
         end
      endcase
   end

endmodule : lacp_rx_ctrl
`default_nettype wire

### rtl/lacp_receive_machine_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lacp receive machine unit
// single port lacp receive machine with controller and datapath
// ----------------------------------------------------------------------------
// one word (a tick or a received lacpdu with its flags) is taken at a time;
// the controller walks state transitions (at most sixteen per item) one a
// cycle through the datapath, and the result is then held until taken
module lacp_receive_machine_unit import lacp_rx_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   // configuration writes
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [SYS_W-1:0]  csr_data,
   // item word
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_op,
   input  wire logic              req_begin_req,
   input  wire logic              req_port_up,
   input  wire logic              req_lacp_on,
   input  wire logic              req_moved_in,
   input  wire logic [SYS_W-1:0]  req_msg_actor_system,
   input  wire logic [PORT_W-1:0] req_msg_actor_port,
   input  wire logic [SYS_W-1:0]  req_msg_partner_system,
   input  wire logic [PORT_W-1:0] req_msg_partner_port,
   // result word
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [2:0]             rsp_rx_state,
   output logic [7:0]             rsp_actor_oper_state,
   output logic [7:0]             rsp_partner_oper_state,
   output logic                   rsp_need_transmit,
   output logic                   rsp_unselect,
   output logic [TICK_W-1:0]      rsp_timer_left
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   // item fields captured at accept so the walk sees a steady copy
   logic              op_ff, begin_ff, up_ff, lacp_ff, moved_ff;
   logic [SYS_W-1:0]  mas_ff, mps_ff;
   logic [PORT_W-1:0] map_ff, mpp_ff;

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         op_ff <= req_op; up_ff <= req_port_up; lacp_ff <= req_lacp_on;
         moved_ff <= req_moved_in; begin_ff <= req_begin_req;
         mas_ff <= req_msg_actor_system; map_ff <= req_msg_actor_port;
         mps_ff <= req_msg_partner_system; mpp_ff <= req_msg_partner_port;
      end
   end

   assign csr_ready = 1'b1;

   lacp_rx_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_begin(req_begin_req),
      .rsp_valid, .rsp_stall, .sts, .cmd
   );

   lacp_rx_datapath u_dp (
      .clock, .reset,
      .csr_valid(csr_valid && csr_ready), .csr_index, .csr_data,
      .item_op(op_ff), .item_begin(begin_ff), .item_up(up_ff),
      .item_lacp(lacp_ff), .item_moved(moved_ff),
      .item_ma_sys(mas_ff), .item_ma_port(map_ff),
      .item_mp_sys(mps_ff), .item_mp_port(mpp_ff),
      .cmd, .sts,
      .rx_state(rsp_rx_state), .actor_oct(rsp_actor_oper_state),
      .partner_oct(rsp_partner_oper_state), .ntt(rsp_need_transmit),
      .unsel(rsp_unselect), .timer(rsp_timer_left)
   );

endmodule : lacp_receive_machine_unit
`default_nettype wire

### rtl/lacp_rx_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lacp receive checker
// port level checks on the item and result words
// ----------------------------------------------------------------------------
module lacp_rx_checker import lacp_rx_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [2:0] rsp_rx_state
);

   // one item at a time: no accept while a result is shown
   a_no_accept_with_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("accept while result pending");

   // a result is never shown in the cycle right after an accept
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !rsp_valid) else $error("result too early");

   a_state_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_rx_state != 3'd7) else $error("bad state code");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_rx_state))
      else $error("stalled result changed");

endmodule : lacp_rx_checker

bind lacp_receive_machine_unit lacp_rx_checker u_chk (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_rx_state
);
`default_nettype wire
